// ===== src/spi_ra_pkg.sv =====
// Shared types and constants for the SPI register access master.
// No dependencies; imported by every module of the block.
`default_nettype none

package spi_ra_pkg;

  // reply codes from the partner and filler bytes
  localparam logic [7:0] CODE_ECHO_CMD  = 8'hC1;
  localparam logic [7:0] CODE_ECHO_ADDR = 8'hC2;
  localparam logic [7:0] CODE_ACK       = 8'h41;
  localparam logic [7:0] CODE_NACK      = 8'h4E;
  localparam logic [7:0] CODE_DUMMY     = 8'h00;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_RX    = 1'b1;

  // configuration register indexes
  localparam logic CFG_READ_OPCODE  = 1'b0;
  localparam logic CFG_WRITE_OPCODE = 1'b1;

  // configuration reset values
  localparam logic [7:0] READ_OPCODE_RST  = 8'h00;
  localparam logic [7:0] WRITE_OPCODE_RST = 8'h80;

  // transfer phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_CMD   = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_RSYNC = 7'b0001000,
    PH_RDATA = 7'b0010000,
    PH_WDATA = 7'b0100000,
    PH_WSYNC = 7'b1000000
  } phase_t;

  // input item
  typedef struct packed {
    logic        kind;
    logic        is_write;
    logic [1:0]  length_code;
    logic [11:0] address;
    logic [63:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        select_active;
    logic        done_res;
    logic        status;
    logic [63:0] read_data;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/spi_ra_step.sv =====
// Transfer state machine: holds the access state and computes one result per item.
// Depends on spi_ra_pkg; state advances only when the top level moves an item.
`default_nettype none

module spi_ra_step
  import spi_ra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire in_item_t  item,
  input  wire logic [7:0] read_opcode,
  input  wire logic [7:0] write_opcode,
  output out_item_t      result
);

  phase_t      phase_r, phase_nxt;
  logic        write_mode_r, write_mode_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [3:0]  byte_total_r, byte_total_nxt;
  logic [7:0]  address_low_r, address_low_nxt;
  logic [63:0] outgoing_r, outgoing_nxt;
  logic [63:0] gathered_r, gathered_nxt;

  logic [3:0]  index_inc;
  logic [63:0] gathered_add;
  logic [7:0]  out_byte;
  logic [7:0]  cmd_byte;

  assign index_inc    = byte_index_r + 4'd1;
  assign gathered_add = gathered_r | ({56'd0, item.rx_byte} << {byte_index_r[2:0], 3'b000});
  assign out_byte     = outgoing_r[{byte_index_r[2:0], 3'b000} +: 8];
  assign cmd_byte     = (item.is_write ? write_opcode : read_opcode)
                      | {2'b00, item.length_code, 4'b0000}
                      | {4'b0000, item.address[11:8]};

  // next state and result for the item at hand
  always_comb begin
    phase_nxt       = phase_r;
    write_mode_nxt  = write_mode_r;
    byte_index_nxt  = byte_index_r;
    byte_total_nxt  = byte_total_r;
    address_low_nxt = address_low_r;
    outgoing_nxt    = outgoing_r;
    gathered_nxt    = gathered_r;
    result          = '0;

    if (item.kind == KIND_START) begin
      if (phase_r != PH_IDLE) begin
        // start while busy is ignored
        result.select_active = 1'b1;
      end else begin
        write_mode_nxt       = item.is_write;
        byte_total_nxt       = 4'd1 << item.length_code;
        byte_index_nxt       = 4'd0;
        address_low_nxt      = item.address[7:0];
        outgoing_nxt         = item.write_data;
        gathered_nxt         = '0;
        phase_nxt            = PH_CMD;
        result.tx_byte       = cmd_byte;
        result.tx_valid      = 1'b1;
        result.select_active = 1'b1;
      end
    end else begin
      // default: a byte that keeps the transfer going
      result.tx_valid      = 1'b1;
      result.select_active = 1'b1;
      result.tx_byte       = CODE_DUMMY;
      unique case (phase_r)
        PH_CMD: begin
          if (item.rx_byte != CODE_ECHO_CMD) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res = 1'b1;
            result.status   = 1'b1;
          end else begin
            phase_nxt      = PH_ADDR;
            result.tx_byte = address_low_r;
          end
        end
        PH_ADDR: begin
          if (item.rx_byte != CODE_ECHO_ADDR) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res = 1'b1;
            result.status   = 1'b1;
          end else if (write_mode_r) begin
            phase_nxt      = PH_WDATA;
            byte_index_nxt = 4'd1;
            result.tx_byte = outgoing_r[7:0];
          end else begin
            phase_nxt = PH_RSYNC;
          end
        end
        PH_RSYNC: begin
          if (item.rx_byte == CODE_ACK) begin
            phase_nxt      = PH_RDATA;
            byte_index_nxt = 4'd0;
          end else if (item.rx_byte != CODE_NACK) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res = 1'b1;
            result.status   = 1'b1;
          end
        end
        PH_RDATA: begin
          gathered_nxt   = gathered_add;
          byte_index_nxt = index_inc;
          if (index_inc >= byte_total_r) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res  = 1'b1;
            result.read_data = gathered_add;
          end
        end
        PH_WDATA: begin
          if (item.rx_byte != CODE_ACK) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res = 1'b1;
            result.status   = 1'b1;
          end else if (byte_index_r < byte_total_r) begin
            result.tx_byte = out_byte;
            byte_index_nxt = index_inc;
          end else begin
            phase_nxt = PH_WSYNC;
          end
        end
        PH_WSYNC: begin
          if (item.rx_byte == CODE_ACK) begin
            phase_nxt = PH_IDLE;
            result    = '0;
            result.done_res = 1'b1;
          end
        end
        default: begin
          // partner byte while idle
          phase_nxt = PH_IDLE;
          result    = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      write_mode_r <= 1'b0;
      byte_index_r <= 4'd0;
      byte_total_r <= 4'd0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      write_mode_r <= write_mode_nxt;
      byte_index_r <= byte_index_nxt;
      byte_total_r <= byte_total_nxt;
    end
  end

  // access payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_low_r <= '0;
      outgoing_r    <= '0;
      gathered_r    <= '0;
    end else if (adv) begin
      address_low_r <= address_low_nxt;
      outgoing_r    <= outgoing_nxt;
      gathered_r    <= gathered_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/spi_register_access_master_core.sv =====
// Top level of the SPI register access master: input register, config registers,
// result register around the spi_ra_step state machine. Depends on spi_ra_pkg.
//
// Usage: send a start item (kind 0) with read/write, length code, address and
// write data; the result carries the command byte to shift out. After each SPI
// byte exchange send the returned byte as an item (kind 1); each result gives
// the next byte to shift, chip select state, and on completion done, status and
// the read data. Exactly one item comes out for every item taken in.
// An accepted item lands in the input register at the accepting edge, is processed
// by spi_ra_step once the result register is free or draining, and its result is
// then held in the result register that drives out_*.
// Throughput: one item per cycle while out_ready stays high, set by the single state
// update between the input register and the result register.
// A stalled receiver (out_ready low) holds the result register; the input
// register still takes one more item, then in_ready drops until the result
// moves on.
// Reset (rst_n low, synchronous) empties both registers, returns to idle and
// loads the opcode bits with 0x00 for reads and 0x80 for writes.
// Configuration writes (cfg_we) take effect at the next edge; make them only
// while no transfer is in flight.
`default_nettype none

module spi_register_access_master_core
  import spi_ra_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic [7:0] read_opcode_r;
  logic [7:0] write_opcode_r;
  logic       adv;
  out_item_t  step_result;

  // process the held item when the result register is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_opcode_r  <= READ_OPCODE_RST;
      write_opcode_r <= WRITE_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_READ_OPCODE:  read_opcode_r  <= cfg_wdata;
        CFG_WRITE_OPCODE: write_opcode_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  spi_ra_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item         (in_item_r),
    .read_opcode  (read_opcode_r),
    .write_opcode (write_opcode_r),
    .result       (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // a finished transfer always releases chip select
  a_done_deselect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.select_active))
    else $error("done item with select still active");

  // error status only with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> out_data.done_res)
    else $error("status set without done");

  // read data only on a successful completion
  a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.read_data != 64'd0)) |->
      (out_data.done_res && !out_data.status))
    else $error("read data outside successful done");

  // a held item with a stalled result blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is full");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for spi_register_access_master_core: directed and random
// register read/write transfers, each result checked against an in-bench predictor.
// Depends on spi_ra_pkg and the block's RTL.
module testbench;
  import spi_ra_pkg::*;

  localparam int HOLD_LEN = 200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_READ_OPCODE;
  logic [7:0] cfg_wdata = 8'h00;

  spi_register_access_master_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the opcode registers and transfer state
  logic [7:0]  rd_opcode = READ_OPCODE_RST;
  logic [7:0]  wr_opcode = WRITE_OPCODE_RST;
  phase_t      xfer_phase = PH_IDLE;
  logic        xfer_write = 1'b0;
  logic [3:0]  byte_idx = 4'd0;
  logic [3:0]  byte_cnt = 4'd0;
  logic [7:0]  addr_lo = 8'h00;
  logic [63:0] tx_data = '0;
  logic [63:0] rx_data = '0;

  // bookkeeping
  in_item_t    item_q[$];
  out_item_t   reply_q[$];
  out_item_t   want;
  int          queued_cnt = 0;
  int          taken_cnt = 0;
  int          results_seen = 0;
  int          n_errors = 0;
  int          in_idle_pct = 18;
  int          out_idle_pct = 18;
  int          hold_left = 0;
  int          next_hold_at = 300;
  int          n_holds = 0;
  int          gen_items = 0;
  int          n_settings = 0;
  int          n_rd_ok = 0;
  int          n_wr_ok = 0;
  int          n_fail = 0;
  int          n_ignored = 0;

  function automatic out_item_t pack_reply(logic [7:0] tx, logic v, logic sel, logic done,
                                           logic st, logic [63:0] rd);
    out_item_t r;
    r.tx_byte       = tx;
    r.tx_valid      = v;
    r.select_active = sel;
    r.done_res      = done;
    r.status        = st;
    r.read_data     = rd;
    return r;
  endfunction

  // end of a transfer, good or bad
  function automatic out_item_t close_xfer(logic err, logic [63:0] rd);
    xfer_phase = PH_IDLE;
    if (err) n_fail++;
    else if (xfer_write) n_wr_ok++;
    else n_rd_ok++;
    return pack_reply(8'h00, 1'b0, 1'b0, 1'b1, err, err ? 64'd0 : rd);
  endfunction

  // one partner exchange of the master: next byte, select and completion
  function automatic out_item_t step_master(in_item_t it);
    logic [7:0]  cmd;
    logic [63:0] shifted;
    out_item_t   r;
    if (it.kind == KIND_START) begin
      if (xfer_phase != PH_IDLE) begin
        n_ignored++;
        return pack_reply(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0);
      end
      xfer_write = it.is_write;
      byte_cnt   = 4'd1 << it.length_code;
      byte_idx   = 4'd0;
      addr_lo    = it.address[7:0];
      tx_data    = it.write_data;
      rx_data    = '0;
      cmd = (it.is_write ? wr_opcode : rd_opcode) | {2'b00, it.length_code, 4'h0}
            | {4'h0, it.address[11:8]};
      xfer_phase = PH_CMD;
      return pack_reply(cmd, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
    end
    case (xfer_phase)
      PH_CMD: begin
        if (it.rx_byte != CODE_ECHO_CMD) begin
          r = close_xfer(1'b1, 64'd0);
        end else begin
          xfer_phase = PH_ADDR;
          r = pack_reply(addr_lo, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end
      end
      PH_ADDR: begin
        if (it.rx_byte != CODE_ECHO_ADDR) begin
          r = close_xfer(1'b1, 64'd0);
        end else if (xfer_write) begin
          xfer_phase = PH_WDATA;
          byte_idx   = 4'd1;
          r = pack_reply(tx_data[7:0], 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end else begin
          xfer_phase = PH_RSYNC;
          r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end
      end
      PH_RSYNC: begin
        if (it.rx_byte == CODE_NACK) begin
          r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end else if (it.rx_byte == CODE_ACK) begin
          xfer_phase = PH_RDATA;
          byte_idx   = 4'd0;
          r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end else begin
          r = close_xfer(1'b1, 64'd0);
        end
      end
      PH_RDATA: begin
        rx_data  = rx_data | ({56'd0, it.rx_byte} << {byte_idx[2:0], 3'b000});
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= byte_cnt) r = close_xfer(1'b0, rx_data);
        else r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
      end
      PH_WDATA: begin
        if (it.rx_byte != CODE_ACK) begin
          r = close_xfer(1'b1, 64'd0);
        end else if (byte_idx < byte_cnt) begin
          shifted  = tx_data >> {byte_idx[2:0], 3'b000};
          byte_idx = byte_idx + 4'd1;
          r = pack_reply(shifted[7:0], 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end else begin
          xfer_phase = PH_WSYNC;
          r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
        end
      end
      PH_WSYNC: begin
        if (it.rx_byte == CODE_ACK) r = close_xfer(1'b0, 64'd0);
        else r = pack_reply(CODE_DUMMY, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0);
      end
      default: begin
        // partner byte with no transfer open
        xfer_phase = PH_IDLE;
        n_ignored++;
        r = pack_reply(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0);
      end
    endcase
    return r;
  endfunction

  // driver: offers queued items, predicts each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(step_master(in_data));
        taken_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (item_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_data  <= item_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result, drives out_ready with random and long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("result %0d with nothing expected: %p", results_seen,
                                       out_data);
        end else begin
          want = reply_q.pop_front();
          if (out_data !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d mismatch (expected/actual): tx_byte %h/%h tx_valid %b/%b",
                       results_seen, want.tx_byte, out_data.tx_byte, want.tx_valid,
                       out_data.tx_valid);
              $display("  select %b/%b done %b/%b status %b/%b read_data %h/%h",
                       want.select_active, out_data.select_active,
                       want.done_res, out_data.done_res, want.status, out_data.status,
                       want.read_data, out_data.read_data);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= next_hold_at && in_valid) begin
        // long hold while the sender keeps offering, fills the block
        hold_left = HOLD_LEN;
        next_hold_at += 700;
        n_holds++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic in_item_t mk_start(logic w, logic [1:0] len, logic [11:0] addr,
                                        logic [63:0] data);
    in_item_t it;
    it.kind        = KIND_START;
    it.is_write    = w;
    it.length_code = len;
    it.address     = addr;
    it.write_data  = data;
    it.rx_byte     = 8'($urandom_range(255));
    return it;
  endfunction

  // partner byte; the unused fields carry noise
  function automatic in_item_t mk_rx(logic [7:0] b);
    in_item_t it;
    it.kind        = KIND_RX;
    it.is_write    = 1'($urandom_range(1));
    it.length_code = 2'($urandom_range(3));
    it.address     = 12'($urandom_range(4095));
    it.write_data  = {$urandom, $urandom};
    it.rx_byte     = b;
    return it;
  endfunction

  function automatic logic [11:0] rand_addr();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return 12'h000;
    if (roll < 30) return 12'hFFF;
    return 12'($urandom_range(4095));
  endfunction

  function automatic logic [63:0] rand_data();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return 64'd0;
    if (roll < 30) return '1;
    return {$urandom, $urandom};
  endfunction

  // wrong reply byte, often a single bit away from the right one
  function automatic logic [7:0] not_byte(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    if ($urandom_range(1) == 0) v = a ^ (8'h01 << $urandom_range(7));
    else v = 8'($urandom_range(255));
    while (v == a || v == b) v = 8'($urandom_range(255));
    return v;
  endfunction

  task automatic push_item(in_item_t it);
    item_q.push_back(it);
    queued_cnt++;
  endtask

  // one random transfer: mostly well formed, some broken, some with a stray start, some stray bytes
  task automatic gen_transfer();
    in_item_t    seq[$];
    int unsigned roll;
    int unsigned len;
    int unsigned n_bytes;
    int unsigned sync_pos;
    int unsigned fail_at;
    int unsigned k;
    logic        w;
    logic [7:0]  bad;
    roll = $urandom_range(99);
    if (roll < 8) begin
      k = $urandom_range(3, 1);
      repeat (k) push_item(mk_rx(8'($urandom_range(255))));
      return;
    end
    w       = 1'($urandom_range(1));
    len     = $urandom_range(3);
    n_bytes = 1 << len;
    seq.push_back(mk_start(w, len[1:0], rand_addr(), rand_data()));
    seq.push_back(mk_rx(CODE_ECHO_CMD));
    seq.push_back(mk_rx(CODE_ECHO_ADDR));
    if (w) begin
      repeat (n_bytes) seq.push_back(mk_rx(CODE_ACK));
      k = $urandom_range(3);
      repeat (k) seq.push_back(mk_rx(not_byte(CODE_ACK, CODE_ACK)));
      seq.push_back(mk_rx(CODE_ACK));
      sync_pos = 2 + n_bytes;
    end else begin
      k = $urandom_range(3);
      repeat (k) seq.push_back(mk_rx(CODE_NACK));
      sync_pos = seq.size();
      seq.push_back(mk_rx(CODE_ACK));
      repeat (n_bytes) seq.push_back(mk_rx(8'($urandom_range(255))));
    end
    if (roll < 23) begin
      // wrong reply at a checked position, nothing sent after it
      fail_at = $urandom_range(sync_pos, 1);
      if (fail_at == 1) bad = not_byte(CODE_ECHO_CMD, CODE_ECHO_CMD);
      else if (fail_at == 2) bad = not_byte(CODE_ECHO_ADDR, CODE_ECHO_ADDR);
      else if (w) bad = not_byte(CODE_ACK, CODE_ACK);
      else bad = not_byte(CODE_ACK, CODE_NACK);
      seq[fail_at] = mk_rx(bad);
      while (seq.size() > fail_at + 1) void'(seq.pop_back());
    end else if (roll >= 88) begin
      // start offered while the transfer is still open
      k = $urandom_range(seq.size() - 1, 1);
      seq.insert(k, mk_start(1'($urandom_range(1)), 2'($urandom_range(3)), rand_addr(),
                             rand_data()));
      gen_items--;
    end
    gen_items += seq.size();
    foreach (seq[i]) push_item(seq[i]);
  endtask

  task automatic wait_drain();
    while (taken_cnt != queued_cnt || reply_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_opcodes(logic [7:0] rd, logic [7:0] wr);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_READ_OPCODE;
    cfg_wdata <= rd;
    @(posedge clk);
    cfg_index <= CFG_WRITE_OPCODE;
    cfg_wdata <= wr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rd_opcode = rd;
    wr_opcode = wr;
    n_settings++;
  endtask

  task automatic run_random(int n);
    int first;
    first = gen_items;
    while (gen_items - first < n) gen_transfer();
    wait_drain();
  endtask

  // stimulus and end of run
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset opcodes
    push_item(mk_rx(CODE_ECHO_CMD));                         // byte with no transfer
    push_item(mk_start(1'b0, 2'd0, 12'hFFF, 64'd0));         // read, one byte
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_rx(CODE_ECHO_ADDR));
    push_item(mk_rx(CODE_ACK));
    push_item(mk_rx(8'hFF));
    push_item(mk_start(1'b1, 2'd0, 12'h000, '1));            // write, one byte
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_rx(CODE_ECHO_ADDR));
    push_item(mk_rx(CODE_ACK));
    push_item(mk_start(1'b0, 2'd3, 12'h123, '1));            // start while busy
    push_item(mk_rx(CODE_NACK));                             // write sync wait
    push_item(mk_rx(CODE_ACK));
    push_item(mk_start(1'b0, 2'd3, 12'h000, 64'd0));         // bad command echo
    push_item(mk_rx(CODE_ECHO_ADDR));
    push_item(mk_start(1'b1, 2'd3, 12'h5A5, '1));            // bad address echo
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_start(1'b0, 2'd1, 12'hA5A, 64'd0));         // bad read sync
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_rx(CODE_ECHO_ADDR));
    push_item(mk_rx(CODE_DUMMY));
    push_item(mk_start(1'b1, 2'd1, 12'hFFF, 64'd0));         // bad data ack
    push_item(mk_rx(CODE_ECHO_CMD));
    push_item(mk_rx(CODE_ECHO_ADDR));
    push_item(mk_rx(CODE_ACK));
    push_item(mk_rx(CODE_NACK));
    wait_drain();

    // random part over several opcode settings
    set_opcodes(8'hFF, 8'hFF);
    run_random(310);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_opcodes(8'h00, 8'h00);
    run_random(310);
    in_idle_pct  = 18;
    out_idle_pct = 18;
    set_opcodes(8'h80, 8'h00);
    run_random(310);
    repeat (3) begin
      set_opcodes(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random(310);
    end
    repeat (10) @(posedge clk);

    $display("covered %0d reads and %0d writes completed, %0d transfers ended on bad replies",
             n_rd_ok, n_wr_ok, n_fail);
    $display("%0d ignored items, %0d opcode settings, %0d long output holds, %0d results",
             n_ignored, n_settings, n_holds, results_seen);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, reply_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout with %0d results still expected", reply_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
